// ===== design/egcd_pkg.sv =====
// Package for the extended GCD block: widths, sequencer states and control structs.
package egcd_pkg;

   // Default operand width used inside the datapath
   localparam int DEF_WIDTH = 32;
   // Fixed port field widths
   localparam int OPND_BITS = 32;
   localparam int DIV_BITS  = 32;
   localparam int COEF_BITS = 33;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_SUB,
      ST_DONE
   } egcd_state_type;

   // Status from the datapath to the sequencer
   typedef struct packed {
      logic req_valid;
      logic rsp_busy;
      logic b_zero;
      logic fits;
      logic k_zero;
      logic rem_zero;
   } egcd_stat_type;

   // Controls from the sequencer to the datapath
   typedef struct packed {
      logic idle;
      logic load;
      logic align_mode;
      logic shift;
      logic sub_step;
      logic final_step;
      logic out_write;
   } egcd_ctrl_type;

endpackage

// ===== design/egcd_alu.sv =====
// Shared compare and subtract unit for the remainder and both coefficient accumulators.
module egcd_alu
   import egcd_pkg::*;
#(
   parameter int WIDTH = DEF_WIDTH
) (
   input  logic                    align_mode,
   input  logic [WIDTH-1:0]        rem,
   input  logic [WIDTH-1:0]        dvs,
   input  logic signed [WIDTH+1:0] coef_x,
   input  logic signed [WIDTH+1:0] shift_x,
   input  logic signed [WIDTH+1:0] coef_y,
   input  logic signed [WIDTH+1:0] shift_y,
   output logic                    fits,
   output logic [WIDTH-1:0]        rem_next,
   output logic signed [WIDTH+1:0] x_next,
   output logic signed [WIDTH+1:0] y_next
);

   logic [WIDTH:0] cmp_op;
   logic [WIDTH:0] rem_ext;

   // Compare the doubled divisor while aligning, the divisor itself while subtracting
   always_comb begin
      if (align_mode) begin
         cmp_op = {dvs, 1'b0};
      end else begin
         cmp_op = {1'b0, dvs};
      end
   end

   assign rem_ext = {1'b0, rem};
   assign fits    = (cmp_op <= rem_ext);

   // Subtract one quotient bit worth of divisor and coefficients
   always_comb begin
      if (fits) begin
         rem_next = rem - dvs;
         x_next   = coef_x - shift_x;
         y_next   = coef_y - shift_y;
      end else begin
         rem_next = rem;
         x_next   = coef_x;
         y_next   = coef_y;
      end
   end

endmodule

// ===== design/egcd_ctrl.sv =====
// Sequencer for the extended GCD block: load, align, subtract and deliver.
module egcd_ctrl
   import egcd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  egcd_stat_type stat,
   output egcd_ctrl_type ctrl
);

   egcd_state_type state_ff;
   egcd_state_type state_in;

   // Advance the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (stat.req_valid) begin
               state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            priority if (stat.b_zero) begin
               state_in = ST_DONE;
            end else if (!stat.fits) begin
               state_in = ST_SUB;
            end else begin
               state_in = ST_ALIGN;
            end
         end
         ST_SUB: begin
            if (stat.k_zero) begin
               if (stat.rem_zero) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_ALIGN;
               end
            end
         end
         ST_DONE: begin
            if (!stat.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.idle = 1'b1;
            ctrl.load = stat.req_valid;
         end
         ST_ALIGN: begin
            ctrl.align_mode = 1'b1;
            ctrl.shift      = !stat.b_zero && stat.fits;
         end
         ST_SUB: begin
            ctrl.sub_step   = 1'b1;
            ctrl.final_step = stat.k_zero;
         end
         ST_DONE: begin
            ctrl.out_write = !stat.rsp_busy;
         end
         default: ctrl = '0;
      endcase
   end

endmodule

// ===== design/extended_gcd_coefficients_top.sv =====
// Extended GCD block with Bezout coefficients: datapath registers and output stage.
// From accept to rsp_valid the sequencer runs an align and a subtract phase for each Euclid
// step, then a done state; if b is zero it goes from align straight to done.
// Throughput: one item at a time; the next item can be accepted in the cycle after the result enters
// the output register; each quotient bit takes one align step and one subtract step.
// Reset (synchronous) returns the sequencer to idle and empties the output register.
module extended_gcd_coefficients_top
   import egcd_pkg::*;
#(
   parameter int WIDTH = DEF_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OPND_BITS-1:0] req_operand_a,
   input  logic [OPND_BITS-1:0] req_operand_b,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [DIV_BITS-1:0]  rsp_divisor,
   output logic [COEF_BITS-1:0] rsp_coef_a,
   output logic [COEF_BITS-1:0] rsp_coef_b
);

   localparam int CW = WIDTH + 2;
   localparam int KW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   egcd_stat_type stat;
   egcd_ctrl_type ctrl;

   logic [WIDTH-1:0]     a_ff, a_in;
   logic [WIDTH-1:0]     b_ff, b_in;
   logic [WIDTH-1:0]     d_ff, d_in;
   logic [KW-1:0]        k_ff, k_in;
   logic signed [CW-1:0] x_ff, x_in;
   logic signed [CW-1:0] y_ff, y_in;
   logic signed [CW-1:0] x1_ff, x1_in;
   logic signed [CW-1:0] y1_ff, y1_in;
   logic signed [CW-1:0] sx_ff, sx_in;
   logic signed [CW-1:0] sy_ff, sy_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DIV_BITS-1:0]  divisor_ff, divisor_in;
   logic [COEF_BITS-1:0] coef_a_ff, coef_a_in;
   logic [COEF_BITS-1:0] coef_b_ff, coef_b_in;

   logic                 fits;
   logic [WIDTH-1:0]     rem_next;
   logic signed [CW-1:0] x_next;
   logic signed [CW-1:0] y_next;

   egcd_alu #(
      .WIDTH(WIDTH)
   ) u_alu (
      .align_mode(ctrl.align_mode),
      .rem       (a_ff),
      .dvs       (d_ff),
      .coef_x    (x_ff),
      .shift_x   (sx_ff),
      .coef_y    (y_ff),
      .shift_y   (sy_ff),
      .fits      (fits),
      .rem_next  (rem_next),
      .x_next    (x_next),
      .y_next    (y_next)
   );

   egcd_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .stat (stat),
      .ctrl (ctrl)
   );

   // Gather status for the sequencer
   always_comb begin
      stat.req_valid = req_valid;
      stat.rsp_busy  = rsp_valid_ff && rsp_stall;
      stat.b_zero    = (b_ff == '0);
      stat.fits      = fits;
      stat.k_zero    = (k_ff == '0);
      stat.rem_zero  = (rem_next == '0);
   end

   // Datapath next values
   always_comb begin
      a_in  = a_ff;
      b_in  = b_ff;
      d_in  = d_ff;
      k_in  = k_ff;
      x_in  = x_ff;
      y_in  = y_ff;
      x1_in = x1_ff;
      y1_in = y1_ff;
      sx_in = sx_ff;
      sy_in = sy_ff;
      if (ctrl.load) begin
         a_in  = WIDTH'(req_operand_a);
         b_in  = WIDTH'(req_operand_b);
         d_in  = WIDTH'(req_operand_b);
         k_in  = '0;
         x_in  = CW'(1);
         y_in  = '0;
         x1_in = '0;
         y1_in = CW'(1);
         sx_in = '0;
         sy_in = CW'(1);
      end else if (ctrl.shift) begin
         // Double the divisor and the shifted coefficients
         d_in  = {d_ff[WIDTH-2:0], 1'b0};
         sx_in = sx_ff <<< 1;
         sy_in = sy_ff <<< 1;
         k_in  = k_ff + KW'(1);
      end else if (ctrl.sub_step) begin
         if (ctrl.final_step) begin
            // Close the division: rotate remainders and coefficient pairs
            a_in  = b_ff;
            b_in  = rem_next;
            d_in  = rem_next;
            x_in  = x1_ff;
            y_in  = y1_ff;
            x1_in = x_next;
            y1_in = y_next;
            sx_in = x_next;
            sy_in = y_next;
            k_in  = '0;
         end else begin
            a_in  = rem_next;
            x_in  = x_next;
            y_in  = y_next;
            d_in  = d_ff >> 1;
            sx_in = sx_ff >>> 1;
            sy_in = sy_ff >>> 1;
            k_in  = k_ff - KW'(1);
         end
      end
   end

   // Hold datapath state
   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      b_ff  <= b_in;
      d_ff  <= d_in;
      k_ff  <= k_in;
      x_ff  <= x_in;
      y_ff  <= y_in;
      x1_ff <= x1_in;
      y1_ff <= y1_in;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
   end

   // Output register next values
   always_comb begin
      divisor_in = divisor_ff;
      coef_a_in  = coef_a_ff;
      coef_b_in  = coef_b_ff;
      if (ctrl.out_write) begin
         divisor_in   = DIV_BITS'(a_ff);
         coef_a_in    = COEF_BITS'(x_ff);
         coef_b_in    = COEF_BITS'(y_ff);
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // Hold the output valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result payload
   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      coef_a_ff  <= coef_a_in;
      coef_b_ff  <= coef_b_in;
   end

   assign req_stall   = !ctrl.idle;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_divisor = divisor_ff;
   assign rsp_coef_a  = coef_a_ff;
   assign rsp_coef_b  = coef_b_ff;

endmodule
